[rtl/core/tcpu_pkg.sv]
package tcpu_pkg;

    localparam int INSTR_W        = 16;
    localparam int DATA_W         = 16;
    localparam int PC_W           = 8;
    localparam int IMM_W          = 8;
    localparam int REGISTER_COUNT = 8;
    localparam int RADDR_W        = $clog2(REGISTER_COUNT);
    // Depth must be a power of two: the memory index is the low address bits.
    localparam int DATA_WORDS     = 256;
    localparam int DADDR_W        = $clog2(DATA_WORDS);

    // Result fields packed from bit 0 up, padded to whole bytes.
    localparam int RESULT_BITS = PC_W + 1 + 1 + 1 + IMM_W + DATA_W;
    localparam int M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        OP_MOV = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_AND = 4'd3,
        OP_OR  = 4'd4,
        OP_SL  = 4'd5,
        OP_SR  = 4'd6,
        OP_SRA = 4'd7,
        OP_LDL = 4'd8,
        OP_LDH = 4'd9,
        OP_CMP = 4'd10,
        OP_JE  = 4'd11,
        OP_JMP = 4'd12,
        OP_LD  = 4'd13,
        OP_ST  = 4'd14,
        OP_HLT = 4'd15
    } op_t;

    // Everything one executed instruction changes or reports.
    typedef struct packed {
        logic               rf_we;
        logic [RADDR_W-1:0] rf_waddr;
        logic [DATA_W-1:0]  rf_wdata;
        logic               st_we;
        logic [DADDR_W-1:0] st_addr;
        logic [DATA_W-1:0]  st_data;
        logic [PC_W-1:0]    pc;
        logic               flag;
        logic               halt;
    } exec_t;

    function automatic op_t instr_op(input logic [INSTR_W-1:0] instr);
        return op_t'(instr[14:11]);
    endfunction

    function automatic logic [RADDR_W-1:0] instr_ra(input logic [INSTR_W-1:0] instr);
        return instr[10:8];
    endfunction

    function automatic logic [RADDR_W-1:0] instr_rb(input logic [INSTR_W-1:0] instr);
        return instr[7:5];
    endfunction

    function automatic logic [IMM_W-1:0] instr_imm(input logic [INSTR_W-1:0] instr);
        return instr[7:0];
    endfunction

endpackage

[rtl/core/tcpu_rf.sv]
module tcpu_rf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [tcpu_pkg::RADDR_W-1:0]  rd_addr_a,
    input  logic [tcpu_pkg::RADDR_W-1:0]  rd_addr_b,
    input  logic                          we,
    input  logic [tcpu_pkg::RADDR_W-1:0]  waddr,
    input  logic [tcpu_pkg::DATA_W-1:0]   wdata,
    output logic [tcpu_pkg::DATA_W-1:0]   rd_data_a,
    output logic [tcpu_pkg::DATA_W-1:0]   rd_data_b
);
    import tcpu_pkg::*;

    logic [DATA_W-1:0]         mem_reg [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0]         rd_a_reg;
    logic [DATA_W-1:0]         rd_b_reg;

    // Unwritten entries read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Write-first: a read of the entry being written returns the new value.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_a_reg <= (we && waddr == rd_addr_a) ? wdata :
                        (vld_reg[rd_addr_a] ? mem_reg[rd_addr_a] : '0);
            rd_b_reg <= (we && waddr == rd_addr_b) ? wdata :
                        (vld_reg[rd_addr_b] ? mem_reg[rd_addr_b] : '0);
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[rtl/core/tcpu_dmem.sv]
module tcpu_dmem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [tcpu_pkg::DADDR_W-1:0]  rd_addr,
    input  logic                          we,
    input  logic [tcpu_pkg::DADDR_W-1:0]  waddr,
    input  logic [tcpu_pkg::DATA_W-1:0]   wdata,
    output logic [tcpu_pkg::DATA_W-1:0]   rd_data
);
    import tcpu_pkg::*;

    logic [DATA_W-1:0]     mem_reg [DATA_WORDS];
    logic [DATA_WORDS-1:0] vld_reg;
    logic [DATA_W-1:0]     rd_reg;

    // One valid bit per word; an unwritten word reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_reg <= (we && waddr == rd_addr) ? wdata :
                      (vld_reg[rd_addr] ? mem_reg[rd_addr] : '0);
        end
    end

    assign rd_data = rd_reg;

endmodule

[rtl/core/tcpu_alu.sv]
module tcpu_alu (
    input  logic [tcpu_pkg::INSTR_W-1:0] instr,
    input  logic [tcpu_pkg::DATA_W-1:0]  opnd_a,
    input  logic [tcpu_pkg::DATA_W-1:0]  opnd_b,
    input  logic [tcpu_pkg::DATA_W-1:0]  mem_rdata,
    input  logic [tcpu_pkg::PC_W-1:0]    pc,
    input  logic                         flag,
    input  logic                         halted,
    output tcpu_pkg::exec_t              exec
);
    import tcpu_pkg::*;

    op_t              op;
    logic [IMM_W-1:0] imm;

    assign op  = instr_op(instr);
    assign imm = instr_imm(instr);

    always_comb begin
        exec          = '0;
        exec.rf_waddr = instr_ra(instr);
        exec.pc       = pc;
        exec.flag     = flag;
        exec.halt     = halted;
        // Once halted, hold all state and report it unchanged.
        if (!halted) begin
            exec.pc = pc + PC_W'(1);
            case (op)
                OP_MOV: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = opnd_b;
                end
                OP_ADD: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = opnd_a + opnd_b;
                end
                OP_SUB: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = opnd_a - opnd_b;
                end
                OP_AND: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = opnd_a & opnd_b;
                end
                OP_OR: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = opnd_a | opnd_b;
                end
                OP_SL: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = {opnd_a[DATA_W-2:0], 1'b0};
                end
                OP_SR: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = {1'b0, opnd_a[DATA_W-1:1]};
                end
                OP_SRA: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = {opnd_a[DATA_W-1], opnd_a[DATA_W-1:1]};
                end
                OP_LDL: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = {opnd_a[DATA_W-1:IMM_W], imm};
                end
                OP_LDH: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = {imm, opnd_a[IMM_W-1:0]};
                end
                OP_CMP: begin
                    exec.flag = (opnd_a == opnd_b);
                end
                OP_JE: begin
                    if (flag) begin
                        exec.pc = PC_W'(imm);
                    end
                end
                OP_JMP: begin
                    exec.pc = PC_W'(imm);
                end
                OP_LD: begin
                    exec.rf_we    = 1'b1;
                    exec.rf_wdata = mem_rdata;
                end
                OP_ST: begin
                    exec.st_we   = 1'b1;
                    exec.st_addr = imm[DADDR_W-1:0];
                    exec.st_data = opnd_a;
                end
                OP_HLT: begin
                    exec.halt = 1'b1;
                end
                default: begin
                    exec.halt = 1'b1;
                end
            endcase
        end
    end

endmodule

[rtl/core/teaching_cpu_16bit_execute_core.sv]
// Execute core of a small 16-bit teaching processor. Each instruction word
// transferred in on the s_ channel is executed and yields exactly one result
// transfer on the m_ channel: the next fetch address, the halt and equality
// flags, and the address and data of a store when the instruction was ST.
// Opcode is instr[14:11] (bit 15 is ignored), register A is instr[10:8],
// register B is instr[7:5], the immediate or memory address is instr[7:0].
// The eight registers and the 256-word data memory read as zero after reset.
// After HLT every later instruction is still answered, but changes nothing.
// Throughput is one instruction per clock cycle with no bubbles while the
// output is not stalled, including back-to-back dependent instructions,
// loads and stores. Operands are read from the register file and data
// memory in the cycle the instruction is taken into the execute register;
// the instruction executes once the output register can take a result, as
// it moves into the output register, where m_tvalid rises. Both storage
// arrays are write-first, so the instruction executing in a cycle hands its
// write straight to the one being read. s_tready falls only while the
// output register is full and m_tready is low.
module teaching_cpu_16bit_execute_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] instr
    input  logic [tcpu_pkg::INSTR_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] fetch_addr, [8] halted, [9] equal_flag, [10] store_valid,
    // [18:11] store_addr, [34:19] store_data, [39:35] zero
    output logic [tcpu_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcpu_pkg::*;

    logic s_xfer;
    logic x_adv;

    // Execute stage: instruction being executed, its operands already read.
    logic               x_valid_reg;
    logic               x_valid_next;
    logic [INSTR_W-1:0] x_instr_reg;

    // Architectural state.
    logic [PC_W-1:0] pc_reg;
    logic            flag_reg;
    logic            halt_reg;

    // Output register.
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    logic [DATA_W-1:0] mem_rdata;
    exec_t             exec;
    logic [IMM_W-1:0]  s_imm;

    // Advance the execute stage whenever the output register can take a result.
    assign x_adv    = x_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !x_valid_reg || x_adv;
    assign s_xfer   = s_tvalid && s_tready;
    assign s_imm    = instr_imm(s_tdata);

    // Operand reads start at the input transfer; writes land as the
    // executing instruction advances.
    tcpu_rf u_rf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_xfer),
        .rd_addr_a (instr_ra(s_tdata)),
        .rd_addr_b (instr_rb(s_tdata)),
        .we        (x_adv && exec.rf_we),
        .waddr     (exec.rf_waddr),
        .wdata     (exec.rf_wdata),
        .rd_data_a (opnd_a),
        .rd_data_b (opnd_b)
    );

    tcpu_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .rd_addr (s_imm[DADDR_W-1:0]),
        .we      (x_adv && exec.st_we),
        .waddr   (exec.st_addr),
        .wdata   (exec.st_data),
        .rd_data (mem_rdata)
    );

    tcpu_alu u_alu (
        .instr     (x_instr_reg),
        .opnd_a    (opnd_a),
        .opnd_b    (opnd_b),
        .mem_rdata (mem_rdata),
        .pc        (pc_reg),
        .flag      (flag_reg),
        .halted    (halt_reg),
        .exec      (exec)
    );

    always_comb begin
        x_valid_next = x_valid_reg;
        if (s_xfer) begin
            x_valid_next = 1'b1;
        end else if (x_adv) begin
            x_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (x_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        // Pack the result; store fields are zero unless this was a store.
        m_data_next = M_TDATA_W'({exec.st_data,
                                  IMM_W'(exec.st_addr),
                                  exec.st_we,
                                  exec.flag,
                                  exec.halt,
                                  exec.pc});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            pc_reg      <= '0;
            flag_reg    <= 1'b0;
            halt_reg    <= 1'b0;
        end else begin
            x_valid_reg <= x_valid_next;
            m_valid_reg <= m_valid_next;
            if (x_adv) begin
                pc_reg   <= exec.pc;
                flag_reg <= exec.flag;
                halt_reg <= exec.halt;
            end
        end
    end

    // Payload registers: load on transfer or advance, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            x_instr_reg <= s_tdata;
        end
        if (x_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/core/tcpu_checker.sv]
module tcpu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tcpu_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcpu_pkg::*;

    logic            m_xfer;
    logic            halt_seen_reg;
    logic [PC_W-1:0] last_pc_reg;

    assign m_xfer = m_tvalid && m_tready;

    // Track the last reported fetch address and whether a halt was reported.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_seen_reg <= 1'b0;
            last_pc_reg   <= '0;
        end else if (m_xfer) begin
            halt_seen_reg <= halt_seen_reg || m_tdata[8];
            last_pc_reg   <= m_tdata[7:0];
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_halt_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> !m_tdata[10])
        else $error("store reported while halted");

    a_halt_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && halt_seen_reg |-> m_tdata[8] && m_tdata[7:0] == last_pc_reg)
        else $error("state changed after halt");

    a_idle_store_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[10] |-> m_tdata[34:11] == '0)
        else $error("store fields nonzero without a store");

endmodule

bind teaching_cpu_16bit_execute_core tcpu_checker u_tcpu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/testbench.sv]
module testbench;
    import tcpu_pkg::*;

    // One result transfer as it appears on m_tdata, lowest field last.
    typedef struct packed {
        logic [DATA_W-1:0] store_data;
        logic [IMM_W-1:0]  store_addr;
        logic              store_valid;
        logic              equal_flag;
        logic              halted;
        logic [PC_W-1:0]   fetch_addr;
    } outcome_t;

    localparam int OUTCOME_BITS  = $bits(outcome_t);
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES  = 10;    // margin for any stray late result
    localparam int PHASE_ITEMS   = 500;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [INSTR_W-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Architectural state of the processor as the testbench sees it.
    logic [DATA_W-1:0] gpr  [REGISTER_COUNT];
    logic [DATA_W-1:0] dmem [DATA_WORDS];
    logic [PC_W-1:0]   cpu_pc;
    logic              cpu_eq;
    logic              cpu_halted;

    // Results due from the block, oldest at the front.
    outcome_t awaited_outcomes [$];

    int  mismatch_count;
    int  quiet_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;

    teaching_cpu_16bit_execute_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Execute one instruction on the shadow state and return what the block
    // must report for it. After a halt nothing changes and no store shows.
    function automatic outcome_t exec_instr(input logic [INSTR_W-1:0] w);
        op_t                op;
        logic [2:0]         ra;
        logic [2:0]         rb;
        logic [IMM_W-1:0]   imm;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [IMM_W-1:0]   maddr;
        outcome_t           r;
        op    = op_t'(w[14:11]);
        ra    = w[10:8];
        rb    = w[7:5];
        imm   = w[7:0];
        maddr = IMM_W'(imm % DATA_WORDS);
        r     = '0;
        if (!cpu_halted) begin
            a      = gpr[ra];
            b      = gpr[rb];
            // The counter advances first; jumps then overwrite it.
            cpu_pc = cpu_pc + 1'b1;
            case (op)
                OP_MOV: gpr[ra] = b;
                OP_ADD: gpr[ra] = a + b;
                OP_SUB: gpr[ra] = a - b;
                OP_AND: gpr[ra] = a & b;
                OP_OR:  gpr[ra] = a | b;
                OP_SL:  gpr[ra] = {a[DATA_W-2:0], 1'b0};
                OP_SR:  gpr[ra] = {1'b0, a[DATA_W-1:1]};
                OP_SRA: gpr[ra] = {a[DATA_W-1], a[DATA_W-1:1]};
                OP_LDL: gpr[ra] = {a[15:8], imm};
                OP_LDH: gpr[ra] = {imm, a[7:0]};
                OP_CMP: cpu_eq = (a == b);
                OP_JE:  if (cpu_eq) cpu_pc = imm;
                OP_JMP: cpu_pc = imm;
                OP_LD:  gpr[ra] = dmem[maddr];
                OP_ST: begin
                    dmem[maddr]   = a;
                    r.store_valid = 1'b1;
                    r.store_addr  = maddr;
                    r.store_data  = a;
                end
                OP_HLT: cpu_halted = 1'b1;
            endcase
        end
        r.fetch_addr = cpu_pc;
        r.halted     = cpu_halted;
        r.equal_flag = cpu_eq;
        return r;
    endfunction

    function automatic logic [INSTR_W-1:0] rr(input op_t op, input int ra, input int rb);
        return {1'b0, op, 3'(ra), 3'(rb), 5'd0};
    endfunction

    function automatic logic [INSTR_W-1:0] ri(input op_t op, input int ra,
                                              input logic [IMM_W-1:0] imm);
        return {1'b0, op, 3'(ra), imm};
    endfunction

    // Random instruction short of a halt. Memory addresses cluster in a few
    // low words so that loads mostly find earlier stores, and compares often
    // name the same register twice so the flag and JE see both outcomes.
    function automatic logic [INSTR_W-1:0] random_instr();
        op_t              op;
        logic [2:0]       ra;
        logic [2:0]       rb;
        logic [IMM_W-1:0] low;
        op = op_t'($urandom_range(0, 14));
        ra = 3'($urandom_range(0, 7));
        rb = ($urandom_range(0, 3) == 0) ? ra : 3'($urandom_range(0, 7));
        if ((op == OP_LD || op == OP_ST) && $urandom_range(0, 2) != 0)
            low = IMM_W'($urandom_range(0, 15));
        else if (op == OP_LDL || op == OP_LDH || op == OP_JE || op == OP_JMP ||
                 op == OP_LD || op == OP_ST)
            low = IMM_W'($urandom);
        else
            low = {rb, 5'($urandom)};
        return {1'($urandom), op, ra, low};
    endfunction

    // Offer one instruction, entered and left at a falling edge. Insert idle
    // cycles first at the current rate, then hold valid until the transfer.
    task automatic send_instr(input logic [INSTR_W-1:0] w);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= INSTR_W'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        awaited_outcomes.push_back(exec_instr(w));
        @(negedge aclk);
    endtask

    // Every opcode but HLT once or more, with the wrap and sign cases of the
    // arithmetic, a taken JE that wraps the counter, and stores at both ends of
    // the address range with a load at the top. Bit 15 is set on a few words.
    task automatic run_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_instr(ri(OP_LDL, 1, 8'hFF));
        send_instr(ri(OP_LDH, 1, 8'hFF) | 16'h8000);   // r1 = FFFF
        send_instr(ri(OP_LDH, 2, 8'h80));               // r2 = 8000
        send_instr(ri(OP_LDL, 3, 8'h01));               // r3 = 0001
        send_instr(rr(OP_MOV, 4, 1));
        send_instr(rr(OP_ADD, 4, 3));                   // FFFF + 1 wraps to 0
        send_instr(rr(OP_SUB, 5, 3) | 16'h8000);        // 0 - 1 wraps to FFFF
        send_instr(rr(OP_MOV, 6, 2));
        send_instr(rr(OP_SL, 6, 0));                    // top bit shifted out
        send_instr(rr(OP_SRA, 2, 0));                   // negative: C000
        send_instr(rr(OP_SR, 1, 0));                    // 7FFF
        send_instr(rr(OP_SRA, 1, 0));                   // positive: 3FFF
        send_instr(rr(OP_AND, 5, 2));
        send_instr(rr(OP_OR, 3, 2));
        send_instr(rr(OP_CMP, 5, 2));                   // equal
        send_instr(ri(OP_JE, 0, 8'hFF));                // taken
        send_instr(rr(OP_MOV, 0, 0));                   // counter wraps to 0
        send_instr(rr(OP_CMP, 1, 2));                   // not equal
        send_instr(ri(OP_JE, 0, 8'h10));                // falls through
        send_instr(ri(OP_JMP, 0, 8'hFE));
        send_instr(ri(OP_ST, 2, 8'hFF));
        send_instr(ri(OP_ST, 3, 8'h00) | 16'h8000);
        send_instr(ri(OP_LD, 7, 8'hFF));
        send_instr(ri(OP_LD, 0, 8'h80));                // never written
        send_instr(rr(OP_ADD, 7, 7));
    endtask

    // Random programs under each idling pattern in turn.
    task automatic run_random();
        int idle_rates  [4];
        int stall_rates [4];
        idle_rates  = '{0, 55, 0, 25};
        stall_rates = '{0, 0, 55, 25};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_rates[p];
            recv_stall_pct = stall_rates[p];
            repeat (PHASE_ITEMS) send_instr(random_instr());
        end
    endtask

    // Ask the receiver for a long hold-off and keep offering back to back so
    // the output register fills and s_tready drops.
    task automatic run_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        repeat (48) send_instr(random_instr());
    endtask

    // Halt last: nothing after it may change, and no store may show.
    task automatic run_halt();
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        send_instr(ri(OP_HLT, 0, 8'h00) | 16'h8000);
        repeat (16) send_instr(random_instr());
        send_instr(ri(OP_ST, 1, 8'h01));
        send_instr(ri(OP_JMP, 0, 8'h55));
        send_instr(ri(OP_HLT, 7, 8'hFF));
    endtask

    // Receiver: stall at the current rate, or hold off for a whole stretch
    // when asked, then drop the request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Check each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUTCOME_BITS-1:0];
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                report_field("fetch_addr", DATA_W'(want.fetch_addr),
                             DATA_W'(got.fetch_addr));
                report_field("halted", DATA_W'(want.halted), DATA_W'(got.halted));
                report_field("equal_flag", DATA_W'(want.equal_flag),
                             DATA_W'(got.equal_flag));
                report_field("store_valid", DATA_W'(want.store_valid),
                             DATA_W'(got.store_valid));
                report_field("store_addr", DATA_W'(want.store_addr),
                             DATA_W'(got.store_addr));
                report_field("store_data", want.store_data, got.store_data);
                report_field("padding", '0,
                             DATA_W'(m_tdata[M_TDATA_W-1:OUTCOME_BITS]));
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        for (int i = 0; i < REGISTER_COUNT; i++) gpr[i] = '0;
        for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
        cpu_pc     = '0;
        cpu_eq     = 1'b0;
        cpu_halted = 1'b0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random();
        run_backpressure();
        run_halt();
        s_tvalid <= 1'b0;

        // Drain: the watchdog covers a result that never comes.
        while (awaited_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/tcpu_pkg.sv
rtl/core/tcpu_rf.sv
rtl/core/tcpu_dmem.sv
rtl/core/tcpu_alu.sv
rtl/core/teaching_cpu_16bit_execute_core.sv
rtl/core/tcpu_checker.sv
tb/testbench.sv
